// ===== sv/pfaq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfaq_pkg;

    // Field widths and limits
    localparam int NODE_W     = 10;
    localparam int LEN_W      = 11;
    localparam int NODES_DEF  = 1024;
    localparam int NODE_SPACE = 1 << NODE_W;
    localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

    // Function codes of an input word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Relation codes of a result word
    localparam logic [1:0] REL_SAME    = 2'd0;
    localparam logic [1:0] REL_B_ABOVE = 2'd1;
    localparam logic [1:0] REL_A_ABOVE = 2'd2;
    localparam logic [1:0] REL_UNREL   = 2'd3;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              link_present;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        relation_code;
        logic [NODE_W-1:0] common_ancestor;
        logic              ancestor_found;
        logic [LEN_W-1:0]  path_length;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_AB_RD,
        ST_AB_CHK,
        ST_BA_RD,
        ST_BA_CHK,
        ST_MK_RD,
        ST_MK_PAR,
        ST_MK_WR,
        ST_FD_RD,
        ST_FD_PAR,
        ST_FD_CHK,
        ST_UN_RD,
        ST_UN_PAR,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_A,
        CUR_B,
        CUR_PAR
    } cur_op_t;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_SAME,
        RES_B_ABOVE,
        RES_A_ABOVE,
        RES_LCA,
        RES_UNREL
    } res_op_t;

    typedef struct packed {
        logic    clr_en;
        logic    take;
        cur_op_t cur_op;
        logic    step_clr;
        logic    rd_par;
        logic    rd_mark;
        logic    mark_wr;
        logic    unmark_wr;
        logic    dir_ba;
        res_op_t res_op;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_query;
        logic a_eq_b;
        logic par_ok;
        logic par_hit;
        logic step_last;
        logic mark_hit;
        logic mark_free;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/parent_forest_ancestor_query.sv =====
// Parent-pointer forest with ancestor queries.
// The input channel (in_valid, in_stall, in_word) carries one word per item.
// A write word (func 0) sets or clears the parent link of node_a; it is taken
// in the idle state and gives no result. A query word (func 1) names two nodes and
// gives one result word on the output channel (out_valid, out_stall, out_word):
// relation, lowest common ancestor with found flag, and path length.
// For two distinct nodes each parent step costs one table read: a read and a
// check state per step while checking whether one node lies above the other,
// a read, a parent and a write state per step while marking the second node's
// ancestors, a read, a parent and a check state per step while searching the
// first node's chain, and a read and a parent state per step while removing
// the marks. Every walk stops after NODES steps.
// After reset both tables are swept clear, one entry a cycle, over all
// min(NODES, 1024) entries; in_stall stays high during the sweep.
// A finished result waits in the output register while out_stall is high; the
// block takes new write words meanwhile and holds a finished query until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module parent_forest_ancestor_query #(
    parameter int NODES = pfaq_pkg::NODES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pfaq_pkg::in_word_t in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pfaq_pkg::out_word_t     out_word
);

    pfaq_pkg::ctrl_cmd_t cmd;
    pfaq_pkg::dp_sts_t   sts;

    // Sequencer
    pfaq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Tables, walk pointer and result registers
    pfaq_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ===== sv/pfaq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfaq_dp #(
    parameter int NODES = pfaq_pkg::NODES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfaq_pkg::ctrl_cmd_t cmd,
    input  wire pfaq_pkg::in_word_t  in_word,
    input  wire logic                out_stall,
    output pfaq_pkg::dp_sts_t        sts,
    output logic                     out_valid,
    output pfaq_pkg::out_word_t      out_word
);

    localparam int DEPTH = (NODES < pfaq_pkg::NODE_SPACE) ? NODES : pfaq_pkg::NODE_SPACE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(NODES + 1);
    localparam int MW    = SW + 1;
    localparam int SUMW  = (SW + 1 > pfaq_pkg::LEN_W) ? SW + 1 : pfaq_pkg::LEN_W;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [SW-1:0]   STEP_MAX  = SW'(NODES);
    localparam logic [SUMW-1:0] SUM_CAP   = SUMW'(pfaq_pkg::LEN_MAX);

    // A node outside the table has no parent and takes no mark.
    function automatic logic in_range(input logic [pfaq_pkg::NODE_W-1:0] node);
        in_range = (32'(node) < 32'(NODES));
    endfunction

    // Storage
    logic [pfaq_pkg::NODE_W:0] parent_mem [DEPTH];
    logic [MW-1:0]             mark_mem   [DEPTH];

    pfaq_pkg::in_word_t          item_reg;
    logic [pfaq_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [SW-1:0]               step_reg, step_next;
    logic [AW-1:0]               clr_reg;
    logic [pfaq_pkg::NODE_W:0]   pdata_reg;
    logic                        par_ok_reg;
    logic [MW-1:0]               mark_rd_reg;
    logic                        mark_ok_reg;
    pfaq_pkg::out_word_t         res_reg, res_next;
    pfaq_pkg::out_word_t         out_reg;
    logic                        out_valid_reg;

    logic [pfaq_pkg::NODE_W-1:0] par_node;
    logic [pfaq_pkg::NODE_W-1:0] target;
    logic                        par_we;
    logic [AW-1:0]               par_wa;
    logic [pfaq_pkg::NODE_W:0]   par_wd;
    logic                        mk_we;
    logic [AW-1:0]               mk_wa;
    logic [MW-1:0]               mk_wd;
    logic [SUMW-1:0]             up_sum, lca_sum;
    logic [pfaq_pkg::LEN_W-1:0]  up_len, lca_len;

    assign par_node = pdata_reg[pfaq_pkg::NODE_W-1:0];
    assign target   = cmd.dir_ba ? item_reg.node_a : item_reg.node_b;

    // Status back to the controller
    assign sts.clear_last = (clr_reg == LAST_ADDR);
    assign sts.in_query   = (in_word.func == pfaq_pkg::FUNC_QUERY);
    assign sts.a_eq_b     = (item_reg.node_a == item_reg.node_b);
    assign sts.par_ok     = par_ok_reg && pdata_reg[pfaq_pkg::NODE_W];
    assign sts.par_hit    = (par_node == target);
    assign sts.step_last  = (step_reg == STEP_MAX);
    assign sts.mark_hit   = mark_ok_reg && mark_rd_reg[MW-1];
    assign sts.mark_free  = mark_ok_reg && !mark_rd_reg[MW-1];
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Parent table write port: clearing pass or a write word.
    always_comb
    begin
        par_we = 1'b0;
        par_wa = clr_reg;
        par_wd = '0;
        if (cmd.clr_en)
        begin
            par_we = 1'b1;
        end
        else if (cmd.take && (in_word.func == pfaq_pkg::FUNC_WRITE)
                 && in_range(in_word.node_a))
        begin
            par_we = 1'b1;
            par_wa = in_word.node_a[AW-1:0];
            par_wd = in_word.link_present ? {1'b1, in_word.node_b} : '0;
        end
    end

    // Mark table write port: clearing pass, marking walk or unmarking walk.
    always_comb
    begin
        mk_we = 1'b0;
        mk_wa = clr_reg;
        mk_wd = '0;
        if (cmd.clr_en)
        begin
            mk_we = 1'b1;
        end
        else if (cmd.mark_wr)
        begin
            mk_we = 1'b1;
            mk_wa = cur_reg[AW-1:0];
            mk_wd = {1'b1, step_reg};
        end
        else if (cmd.unmark_wr && in_range(par_node))
        begin
            mk_we = 1'b1;
            mk_wa = par_node[AW-1:0];
        end
    end

    // Parent table
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_wa] <= par_wd;
        end
        if (cmd.rd_par)
        begin
            pdata_reg <= parent_mem[cur_reg[AW-1:0]];
        end
    end

    // Mark table holds the step count at which the second node's walk met each node.
    always_ff @(posedge clk)
    begin
        if (mk_we)
        begin
            mark_mem[mk_wa] <= mk_wd;
        end
        if (cmd.rd_mark)
        begin
            mark_rd_reg <= mark_mem[par_node[AW-1:0]];
        end
    end

    // Walk pointer and step counter
    always_comb
    begin
        unique case (cmd.cur_op)
            pfaq_pkg::CUR_HOLD: cur_next = cur_reg;
            pfaq_pkg::CUR_A:    cur_next = item_reg.node_a;
            pfaq_pkg::CUR_B:    cur_next = item_reg.node_b;
            pfaq_pkg::CUR_PAR:  cur_next = par_node;
            default:            cur_next = cur_reg;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (cmd.step_clr)
        begin
            step_next = '0;
        end
        else if (cmd.rd_par)
        begin
            step_next = step_reg + SW'(1);
        end
    end

    // Path lengths, saturated to the field range
    assign up_sum  = SUMW'(step_reg);
    assign lca_sum = SUMW'(step_reg) + SUMW'(mark_rd_reg[SW-1:0]);
    assign up_len  = (up_sum > SUM_CAP) ? pfaq_pkg::LEN_MAX : up_sum[pfaq_pkg::LEN_W-1:0];
    assign lca_len = (lca_sum > SUM_CAP) ? pfaq_pkg::LEN_MAX : lca_sum[pfaq_pkg::LEN_W-1:0];

    // Result under construction
    always_comb
    begin
        res_next = res_reg;
        unique case (cmd.res_op)
            pfaq_pkg::RES_HOLD:
            begin
                res_next = res_reg;
            end
            pfaq_pkg::RES_SAME:
            begin
                res_next.relation_code   = pfaq_pkg::REL_SAME;
                res_next.common_ancestor = item_reg.node_a;
                res_next.ancestor_found  = 1'b1;
                res_next.path_length     = '0;
            end
            pfaq_pkg::RES_B_ABOVE:
            begin
                res_next.relation_code   = pfaq_pkg::REL_B_ABOVE;
                res_next.common_ancestor = item_reg.node_b;
                res_next.ancestor_found  = 1'b1;
                res_next.path_length     = up_len;
            end
            pfaq_pkg::RES_A_ABOVE:
            begin
                res_next.relation_code   = pfaq_pkg::REL_A_ABOVE;
                res_next.common_ancestor = item_reg.node_a;
                res_next.ancestor_found  = 1'b1;
                res_next.path_length     = up_len;
            end
            pfaq_pkg::RES_LCA:
            begin
                res_next.relation_code   = pfaq_pkg::REL_UNREL;
                res_next.common_ancestor = cur_reg;
                res_next.ancestor_found  = 1'b1;
                res_next.path_length     = lca_len;
            end
            pfaq_pkg::RES_UNREL:
            begin
                res_next.relation_code   = pfaq_pkg::REL_UNREL;
                res_next.common_ancestor = '0;
                res_next.ancestor_found  = 1'b0;
                res_next.path_length     = '0;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= in_word;
        end
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            step_reg      <= '0;
            par_ok_reg    <= 1'b0;
            mark_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            step_reg <= step_next;
            if (cmd.rd_par)
            begin
                par_ok_reg <= in_range(cur_reg);
            end
            if (cmd.rd_mark)
            begin
                mark_ok_reg <= in_range(par_node);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Only one user of the mark write port at a time.
    a_mark_port: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_en, cmd.mark_wr, cmd.unmark_wr}))
        else $error("mark table write port driven by two users");

    // A node is marked only on its first visit.
    a_mark_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> (mark_ok_reg && !mark_rd_reg[MW-1]))
        else $error("mark written over an existing mark");

    // Walks never run beyond the step limit.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MAX)
        else $error("walk step counter beyond limit");

    // A loaded result never overwrites one still waiting.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.out_load)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/pfaq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfaq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire pfaq_pkg::dp_sts_t sts,
    output logic                   in_stall,
    output pfaq_pkg::ctrl_cmd_t    cmd
);

    pfaq_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfaq_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfaq_pkg::ST_CLEAR:
                if (sts.clear_last) state_next = pfaq_pkg::ST_IDLE;
            pfaq_pkg::ST_IDLE:
                if (in_valid && sts.in_query) state_next = pfaq_pkg::ST_START;
            pfaq_pkg::ST_START:
                state_next = sts.a_eq_b ? pfaq_pkg::ST_FIN : pfaq_pkg::ST_AB_RD;
            pfaq_pkg::ST_AB_RD:
                state_next = pfaq_pkg::ST_AB_CHK;
            pfaq_pkg::ST_AB_CHK:
                if (!sts.par_ok) state_next = pfaq_pkg::ST_BA_RD;
                else if (sts.par_hit) state_next = pfaq_pkg::ST_FIN;
                else if (sts.step_last) state_next = pfaq_pkg::ST_BA_RD;
                else state_next = pfaq_pkg::ST_AB_RD;
            pfaq_pkg::ST_BA_RD:
                state_next = pfaq_pkg::ST_BA_CHK;
            pfaq_pkg::ST_BA_CHK:
                if (!sts.par_ok) state_next = pfaq_pkg::ST_MK_RD;
                else if (sts.par_hit) state_next = pfaq_pkg::ST_FIN;
                else if (sts.step_last) state_next = pfaq_pkg::ST_MK_RD;
                else state_next = pfaq_pkg::ST_BA_RD;
            pfaq_pkg::ST_MK_RD:
                state_next = pfaq_pkg::ST_MK_PAR;
            pfaq_pkg::ST_MK_PAR:
                state_next = sts.par_ok ? pfaq_pkg::ST_MK_WR : pfaq_pkg::ST_FD_RD;
            pfaq_pkg::ST_MK_WR:
                state_next = sts.step_last ? pfaq_pkg::ST_FD_RD : pfaq_pkg::ST_MK_RD;
            pfaq_pkg::ST_FD_RD:
                state_next = pfaq_pkg::ST_FD_PAR;
            pfaq_pkg::ST_FD_PAR:
                state_next = sts.par_ok ? pfaq_pkg::ST_FD_CHK : pfaq_pkg::ST_UN_RD;
            pfaq_pkg::ST_FD_CHK:
                if (sts.mark_hit || sts.step_last) state_next = pfaq_pkg::ST_UN_RD;
                else state_next = pfaq_pkg::ST_FD_RD;
            pfaq_pkg::ST_UN_RD:
                state_next = pfaq_pkg::ST_UN_PAR;
            pfaq_pkg::ST_UN_PAR:
                if (!sts.par_ok || sts.step_last) state_next = pfaq_pkg::ST_FIN;
                else state_next = pfaq_pkg::ST_UN_RD;
            pfaq_pkg::ST_FIN:
                if (sts.out_free) state_next = pfaq_pkg::ST_IDLE;
            default:
                state_next = pfaq_pkg::ST_CLEAR;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.cur_op = pfaq_pkg::CUR_HOLD;
        cmd.res_op = pfaq_pkg::RES_HOLD;
        in_stall   = 1'b1;
        unique case (state_reg)
            pfaq_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            pfaq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            pfaq_pkg::ST_START:
            begin
                if (sts.a_eq_b)
                begin
                    cmd.res_op = pfaq_pkg::RES_SAME;
                end
                else
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_A;
                    cmd.step_clr = 1'b1;
                end
            end
            pfaq_pkg::ST_AB_RD, pfaq_pkg::ST_BA_RD, pfaq_pkg::ST_MK_RD,
            pfaq_pkg::ST_FD_RD, pfaq_pkg::ST_UN_RD:
            begin
                cmd.rd_par = 1'b1;
            end
            pfaq_pkg::ST_AB_CHK:
            begin
                if (sts.par_ok && sts.par_hit)
                begin
                    cmd.res_op = pfaq_pkg::RES_B_ABOVE;
                end
                else if (!sts.par_ok || sts.step_last)
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_B;
                    cmd.step_clr = 1'b1;
                end
                else
                begin
                    cmd.cur_op = pfaq_pkg::CUR_PAR;
                end
            end
            pfaq_pkg::ST_BA_CHK:
            begin
                cmd.dir_ba = 1'b1;
                if (sts.par_ok && sts.par_hit)
                begin
                    cmd.res_op = pfaq_pkg::RES_A_ABOVE;
                end
                else if (!sts.par_ok || sts.step_last)
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_B;
                    cmd.step_clr = 1'b1;
                    cmd.res_op   = pfaq_pkg::RES_UNREL;
                end
                else
                begin
                    cmd.cur_op = pfaq_pkg::CUR_PAR;
                end
            end
            pfaq_pkg::ST_MK_PAR:
            begin
                if (sts.par_ok)
                begin
                    cmd.cur_op  = pfaq_pkg::CUR_PAR;
                    cmd.rd_mark = 1'b1;
                end
                else
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_A;
                    cmd.step_clr = 1'b1;
                end
            end
            pfaq_pkg::ST_MK_WR:
            begin
                cmd.mark_wr = sts.mark_free;
                if (sts.step_last)
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_A;
                    cmd.step_clr = 1'b1;
                end
            end
            pfaq_pkg::ST_FD_PAR:
            begin
                if (sts.par_ok)
                begin
                    cmd.cur_op  = pfaq_pkg::CUR_PAR;
                    cmd.rd_mark = 1'b1;
                end
                else
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_B;
                    cmd.step_clr = 1'b1;
                end
            end
            pfaq_pkg::ST_FD_CHK:
            begin
                if (sts.mark_hit)
                begin
                    cmd.res_op = pfaq_pkg::RES_LCA;
                end
                if (sts.mark_hit || sts.step_last)
                begin
                    cmd.cur_op   = pfaq_pkg::CUR_B;
                    cmd.step_clr = 1'b1;
                end
            end
            pfaq_pkg::ST_UN_PAR:
            begin
                if (sts.par_ok)
                begin
                    cmd.cur_op    = pfaq_pkg::CUR_PAR;
                    cmd.unmark_wr = 1'b1;
                end
            end
            pfaq_pkg::ST_FIN:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.clr_en = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/tb_parent_forest_ancestor_query.sv =====
`timescale 1ns / 1ps

module tb_parent_forest_ancestor_query;

    localparam int N_NODES     = pfaq_pkg::NODES_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_WORDS = 475;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        pfaq_pkg::in_word_t  w;
        bit                  typed;
        pfaq_pkg::out_word_t ans;
    } probe_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    pfaq_pkg::in_word_t  in_word;
    logic                out_valid;
    logic                out_stall;
    pfaq_pkg::out_word_t out_word;

    // Shadow copy of the parent table: bit 10 marks a live link.
    logic [10:0] parent_tbl [N_NODES];
    int          mark_dist [N_NODES];

    pfaq_pkg::out_word_t pending_answers [$];
    probe_row_t          probe_rows [$];
    pfaq_pkg::out_word_t want;
    int                  err_cnt      = 0;
    int                  cycles       = 0;
    int                  snd_idle_pct = 17;
    int                  rcv_idle_pct = 85;

    parent_forest_ancestor_query DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Look up the parent of one node; nodes past the table have none.
    function automatic bit parent_of(input logic [9:0] n, output logic [9:0] p);
        p = '0;
        if (int'(n) >= N_NODES || !parent_tbl[n][10])
            return 1'b0;
        p = parent_tbl[n][9:0];
        return 1'b1;
    endfunction

    // Parent steps from origin up to target, or 0 if not met within the walk bound.
    function automatic int steps_between(input logic [9:0] origin, input logic [9:0] target);
        logic [9:0] cur;
        logic [9:0] p;
        cur = origin;
        for (int s = 1; s <= N_NODES; s++)
        begin
            if (!parent_of(cur, p))
                return 0;
            cur = p;
            if (cur == target)
                return s;
        end
        return 0;
    endfunction

    // Relation, lowest common ancestor and path length of two nodes.
    function automatic pfaq_pkg::out_word_t answer_query(input logic [9:0] a,
                                                         input logic [9:0] b);
        pfaq_pkg::out_word_t r;
        int                  d;
        int                  len;
        logic [9:0]          cur;
        logic [9:0]          p;
        r   = '0;
        len = 0;
        if (a == b)
        begin
            r.relation_code   = pfaq_pkg::REL_SAME;
            r.common_ancestor = a;
            r.ancestor_found  = 1'b1;
        end
        else
        begin
            d = steps_between(a, b);
            if (d != 0)
            begin
                r.relation_code   = pfaq_pkg::REL_B_ABOVE;
                r.common_ancestor = b;
                r.ancestor_found  = 1'b1;
                len = d;
            end
            else
            begin
                d = steps_between(b, a);
                if (d != 0)
                begin
                    r.relation_code   = pfaq_pkg::REL_A_ABOVE;
                    r.common_ancestor = a;
                    r.ancestor_found  = 1'b1;
                    len = d;
                end
                else
                begin
                    r.relation_code = pfaq_pkg::REL_UNREL;
                    foreach (mark_dist[i])
                        mark_dist[i] = 0;
                    // Tag every ancestor of b with one more than its first distance.
                    cur = b;
                    for (int s = 1; s <= N_NODES; s++)
                    begin
                        if (!parent_of(cur, p))
                            break;
                        cur = p;
                        if (int'(cur) < N_NODES && mark_dist[cur] == 0)
                            mark_dist[cur] = s + 1;
                    end
                    // The first tagged ancestor of a is the lowest common one.
                    cur = a;
                    for (int s = 1; s <= N_NODES; s++)
                    begin
                        if (!parent_of(cur, p))
                            break;
                        cur = p;
                        if (int'(cur) < N_NODES && mark_dist[cur] != 0)
                        begin
                            r.common_ancestor = cur;
                            r.ancestor_found  = 1'b1;
                            len = s + mark_dist[cur] - 1;
                            break;
                        end
                    end
                end
            end
        end
        if (len > int'(pfaq_pkg::LEN_MAX))
            len = int'(pfaq_pkg::LEN_MAX);
        r.path_length = len[pfaq_pkg::LEN_W-1:0];
        return r;
    endfunction

    function automatic probe_row_t link_row(input int a, input int b, input bit link);
        probe_row_t r;
        r = '{default: '0};
        r.w.func         = pfaq_pkg::FUNC_WRITE;
        r.w.node_a       = a[9:0];
        r.w.node_b       = b[9:0];
        r.w.link_present = link;
        return r;
    endfunction

    function automatic probe_row_t ask_row(input int a, input int b);
        probe_row_t r;
        r = '{default: '0};
        r.w.func         = pfaq_pkg::FUNC_QUERY;
        r.w.node_a       = a[9:0];
        r.w.node_b       = b[9:0];
        r.w.link_present = a[0];
        return r;
    endfunction

    function automatic probe_row_t ask_row_known(input int a, input int b,
                                                 input logic [1:0] rel, input int anc,
                                                 input bit fnd, input int len);
        probe_row_t r;
        r = ask_row(a, b);
        r.typed                 = 1'b1;
        r.ans.relation_code     = rel;
        r.ans.common_ancestor   = anc[9:0];
        r.ans.ancestor_found    = fnd;
        r.ans.path_length       = len[pfaq_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Offer one word, wait for it to be taken, then update the shadow table
    // or queue the answer the query should produce.
    task automatic send_word(input pfaq_pkg::in_word_t w, input bit typed,
                             input pfaq_pkg::out_word_t typed_ans);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        if (w.func == pfaq_pkg::FUNC_QUERY)
            pending_answers.push_back(typed ? typed_ans : answer_query(w.node_a, w.node_b));
        else if (int'(w.node_a) < N_NODES)
            parent_tbl[w.node_a] = w.link_present ? {1'b1, w.node_b} : 11'd0;
        @(negedge clk);
    endtask

    // Random words grouped into episodes on a narrow band of nodes, so that
    // trees grow a few levels deep. Links always point to a higher index,
    // which keeps the forest free of loops and the walks short.
    task automatic run_phase(input int n_words);
        pfaq_pkg::in_word_t w;
        int                 sent;
        int                 base;
        int                 span;
        int                 ep_len;
        int                 kind;
        int                 c;
        int                 k;
        sent = 0;
        while (sent < n_words)
        begin
            span   = $urandom_range(4, 40);
            base   = $urandom_range(0, N_NODES - 1 - span);
            ep_len = $urandom_range(10, 40);
            for (k = 0; k < ep_len && sent < n_words; k++)
            begin
                kind = $urandom_range(0, 99);
                w    = '0;
                w.link_present = 1'($urandom_range(0, 1));
                if (kind < 40)
                begin
                    c = base + $urandom_range(0, span - 1);
                    w.func         = pfaq_pkg::FUNC_WRITE;
                    w.node_a       = c[9:0];
                    w.node_b       = 10'($urandom_range(c + 1, base + span));
                    w.link_present = 1'b1;
                end
                else if (kind < 50)
                begin
                    w.func         = pfaq_pkg::FUNC_WRITE;
                    w.node_a       = 10'(base + $urandom_range(0, span));
                    w.node_b       = 10'($urandom_range(0, N_NODES - 1));
                    w.link_present = 1'b0;
                end
                else if (kind < 88)
                begin
                    w.func   = pfaq_pkg::FUNC_QUERY;
                    w.node_a = 10'(base + $urandom_range(0, span));
                    w.node_b = ($urandom_range(0, 7) == 0) ? w.node_a
                               : 10'(base + $urandom_range(0, span));
                end
                else if (kind < 94)
                begin
                    c = $urandom_range(0, N_NODES - 2);
                    w.func   = pfaq_pkg::FUNC_WRITE;
                    w.node_a = c[9:0];
                    w.node_b = 10'($urandom_range(c + 1, N_NODES - 1));
                end
                else
                begin
                    w.func   = pfaq_pkg::FUNC_QUERY;
                    w.node_a = 10'($urandom_range(0, N_NODES - 1));
                    w.node_b = 10'($urandom_range(0, N_NODES - 1));
                end
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver back-pressure, redrawn every cycle.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Compare each result word taken with the oldest pending answer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("ERROR: result word with no query pending: %s",
                             $sformatf("rel=%0d anc=%0d fnd=%0d len=%0d",
                                       out_word.relation_code,
                                       out_word.common_ancestor,
                                       out_word.ancestor_found,
                                       out_word.path_length));
                err_cnt++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (out_word.relation_code !== want.relation_code
                    || out_word.common_ancestor !== want.common_ancestor
                    || out_word.ancestor_found !== want.ancestor_found
                    || out_word.path_length !== want.path_length)
                begin
                    if (err_cnt < 10)
                        $display("ERROR: exp rel=%0d anc=%0d fnd=%0d len=%0d, %s",
                                 want.relation_code, want.common_ancestor,
                                 want.ancestor_found, want.path_length,
                                 $sformatf("got rel=%0d anc=%0d fnd=%0d len=%0d",
                                           out_word.relation_code,
                                           out_word.common_ancestor,
                                           out_word.ancestor_found,
                                           out_word.path_length));
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        foreach (parent_tbl[i])
            parent_tbl[i] = 11'd0;

        // Directed words: empty table, extreme indexes, chains, loops and a self link.
        probe_rows.push_back(ask_row_known(0, 0, pfaq_pkg::REL_SAME, 0, 1'b1, 0));
        probe_rows.push_back(ask_row_known(1023, 1023, pfaq_pkg::REL_SAME, 1023, 1'b1, 0));
        probe_rows.push_back(ask_row_known(0, 1023, pfaq_pkg::REL_UNREL, 0, 1'b0, 0));
        probe_rows.push_back(ask_row_known(682, 341, pfaq_pkg::REL_UNREL, 0, 1'b0, 0));
        probe_rows.push_back(link_row(5, 1023, 1'b1));
        probe_rows.push_back(link_row(0, 5, 1'b1));
        probe_rows.push_back(ask_row(0, 1023));
        probe_rows.push_back(ask_row(1023, 0));
        probe_rows.push_back(ask_row(5, 1023));
        probe_rows.push_back(link_row(7, 1023, 1'b1));
        probe_rows.push_back(ask_row(0, 7));
        probe_rows.push_back(link_row(5, 341, 1'b0));
        probe_rows.push_back(ask_row(0, 7));
        // A two-node loop, then a walk that has to run out its step bound.
        probe_rows.push_back(link_row(100, 101, 1'b1));
        probe_rows.push_back(link_row(101, 100, 1'b1));
        probe_rows.push_back(ask_row(100, 101));
        probe_rows.push_back(ask_row(101, 100));
        probe_rows.push_back(ask_row(100, 200));
        probe_rows.push_back(link_row(102, 100, 1'b1));
        probe_rows.push_back(ask_row(102, 101));
        probe_rows.push_back(link_row(300, 300, 1'b1));
        probe_rows.push_back(ask_row(300, 301));
        // Break the loops before the random part.
        probe_rows.push_back(link_row(100, 682, 1'b0));
        probe_rows.push_back(link_row(101, 0, 1'b0));
        probe_rows.push_back(link_row(300, 1023, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probe_rows[i])
            send_word(probe_rows[i].w, probe_rows[i].typed, probe_rows[i].ans);

        run_phase(PHASE_WORDS);
        snd_idle_pct = 85;
        rcv_idle_pct = 17;
        run_phase(PHASE_WORDS);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(PHASE_WORDS);
        in_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
